### src/rcfb_pkg.sv
package rcfb_pkg;

    typedef logic [31:0] pixel_t;
    typedef logic [7:0]  chan_t;

    localparam chan_t ALPHA_MAX = 8'd255;

endpackage

### src/rcfb_store.sv
module rcfb_store #(
    parameter int DEPTH = 65536,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  rcfb_pkg::pixel_t      wdata,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output rcfb_pkg::pixel_t      rdata
);

    rcfb_pkg::pixel_t mem [DEPTH];
    rcfb_pkg::pixel_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/rcfb_blend.sv
module rcfb_blend (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  rcfb_pkg::pixel_t src,
    input  rcfb_pkg::pixel_t dst,
    output logic             done,
    output rcfb_pkg::pixel_t pix
);

    localparam logic [1:0] LAST_CH = 2'd3;

    logic             active_reg;
    logic             active_next;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic             done_reg;
    logic             done_next;
    rcfb_pkg::pixel_t src_reg;
    rcfb_pkg::pixel_t dst_reg;
    rcfb_pkg::pixel_t pix_reg;
    logic [15:0]      sum_reg;
    logic [15:0]      sum_next;
    logic [23:0]      acc_reg;
    logic [23:0]      merged;

    rcfb_pkg::chan_t alpha;
    rcfb_pkg::chan_t inv_alpha;
    rcfb_pkg::chan_t s_ch;
    rcfb_pkg::chan_t d_ch;
    logic [15:0]     prod_s;
    logic [15:0]     prod_d;
    logic [15:0]     quot_tmp;

    // One colour channel is multiplied per cycle; the quotient by 255 of the
    // previous channel is formed in the same cycle from the registered sum.
    always_comb
    begin
        alpha     = src_reg[31:24];
        inv_alpha = rcfb_pkg::ALPHA_MAX - alpha;
        s_ch      = src_reg[{cnt_reg, 3'b000} +: 8];
        d_ch      = dst_reg[{cnt_reg, 3'b000} +: 8];
        prod_s    = s_ch * alpha;
        prod_d    = d_ch * inv_alpha;
        sum_next  = prod_s + prod_d;
        quot_tmp  = sum_reg + 16'd1 + (sum_reg >> 8);
        merged    = {quot_tmp[15:8], acc_reg[23:8]};
    end

    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        done_next   = active_reg && (cnt_reg == LAST_CH);
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
        end
        else if (active_reg)
        begin
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == LAST_CH)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            src_reg <= src;
            dst_reg <= dst;
        end
        if (active_reg)
        begin
            sum_reg <= sum_next;
            if (cnt_reg != 2'd0)
            begin
                acc_reg <= merged;
            end
            if (cnt_reg == LAST_CH)
            begin
                priority if (alpha == rcfb_pkg::ALPHA_MAX)
                begin
                    pix_reg <= src_reg;
                end
                else if (alpha == 8'd0)
                begin
                    pix_reg <= dst_reg;
                end
                else
                begin
                    pix_reg <= {rcfb_pkg::ALPHA_MAX, merged};
                end
            end
        end
    end

    assign done = done_reg;
    assign pix  = pix_reg;

endmodule

### src/clipped_rect_fill_blend_engine.sv
// Rectangle fill, alpha blend, outline and pixel read engine over an on-chip
// store of MAX_WIDTH * MAX_HEIGHT ARGB pixels, addressed as y * width + x.
// After reset the store is swept to zero, one word a cycle; no command is
// taken until the sweep ends, though register writes are. One command is
// worked on at a time. An opaque fill or clear first clips each rectangle,
// then writes one pixel a cycle through the store's single write port. An
// alpha fill reads each pixel, blends it in the blend unit, which visits one
// colour channel a cycle, and writes it back before it reads the next. An
// outline is four one-pixel rectangles. A pixel read checks the position
// against the screen and reads the store. Every command returns one item on
// the result channel: the pixel value for a read inside the screen, zero
// otherwise.
module clipped_rect_fill_blend_engine #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          command,
    input  logic signed [12:0]  pos_x,
    input  logic signed [12:0]  pos_y,
    input  logic signed [13:0]  rect_w,
    input  logic signed [13:0]  rect_h,
    input  logic [31:0]         fill_color,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [31:0]         read_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [13:0]         cfg_data
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int AW1   = AW + 1;
    localparam int RW    = YW + WW + 1;

    localparam logic [2:0] CMD_CLEAR   = 3'd0;
    localparam logic [2:0] CMD_FILL    = 3'd1;
    localparam logic [2:0] CMD_ALPHA   = 3'd2;
    localparam logic [2:0] CMD_OUTLINE = 3'd3;
    localparam logic [2:0] CMD_READ    = 3'd4;

    localparam logic [2:0] REG_SCR_W  = 3'd0;
    localparam logic [2:0] REG_SCR_H  = 3'd1;
    localparam logic [2:0] REG_CLIP_L = 3'd2;
    localparam logic [2:0] REG_CLIP_T = 3'd3;
    localparam logic [2:0] REG_CLIP_W = 3'd4;
    localparam logic [2:0] REG_CLIP_H = 3'd5;

    localparam logic [1:0] PHASE_LAST = 2'd3;

    typedef logic signed [15:0] coord_t;

    typedef enum logic [9:0] {
        S_INIT  = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_CLIP  = 10'b00_0000_0100,
        S_ROW   = 10'b00_0000_1000,
        S_SCAN  = 10'b00_0001_0000,
        S_BWAIT = 10'b00_0010_0000,
        S_BMIX  = 10'b00_0100_0000,
        S_READ  = 10'b00_1000_0000,
        S_RWAIT = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } state_t;

    // Configuration registers.
    logic [8:0]         scr_w_reg;
    logic [8:0]         scr_h_reg;
    logic signed [12:0] clip_l_reg;
    logic signed [12:0] clip_t_reg;
    logic signed [13:0] clip_w_reg;
    logic signed [13:0] clip_h_reg;

    // Command fields.
    logic [2:0]         cmd_reg;
    logic signed [12:0] x_reg;
    logic signed [12:0] y_reg;
    logic signed [13:0] w_reg;
    logic signed [13:0] h_reg;
    rcfb_pkg::pixel_t   color_reg;

    state_t             state_reg;
    state_t             state_next;
    logic [1:0]         phase_reg;
    logic [1:0]         phase_next;
    logic [WW-1:0]      i_reg;
    logic [WW-1:0]      i_next;
    logic [WW-1:0]      x0_reg;
    logic [WW-1:0]      x0_next;
    logic [WW-1:0]      x1_reg;
    logic [WW-1:0]      x1_next;
    logic [HW-1:0]      j_reg;
    logic [HW-1:0]      j_next;
    logic [HW-1:0]      y1_reg;
    logic [HW-1:0]      y1_next;
    logic [AW-1:0]      row_base_reg;
    logic [AW-1:0]      row_base_next;
    logic [AW-1:0]      init_cnt_reg;
    logic [AW-1:0]      init_cnt_next;
    rcfb_pkg::pixel_t   res_reg;
    rcfb_pkg::pixel_t   res_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    rcfb_pkg::pixel_t   read_data_reg;
    rcfb_pkg::pixel_t   read_data_next;

    logic [WW-1:0]      sw;
    logic [HW-1:0]      sh;
    coord_t             sw_c;
    coord_t             sh_c;

    coord_t             rx;
    coord_t             ry;
    coord_t             rw;
    coord_t             rh;
    coord_t             cr;
    coord_t             cb;
    coord_t             bx0;
    coord_t             bx1;
    coord_t             by0;
    coord_t             by1;
    logic               rect_empty;

    logic               rd_in_range;
    logic [YW+WW-1:0]   rd_prod;
    logic [RW-1:0]      rd_sum;
    logic [HW+WW-1:0]   row_prod;
    logic [AW:0]        row_step;
    logic [AW:0]        pix_sum;
    logic [AW-1:0]      pix_addr;
    logic [WW-1:0]      i_inc;
    logic [HW-1:0]      j_inc;
    logic               last_col;
    logic               last_row;
    logic               pix_step;
    logic               rect_finish;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    rcfb_pkg::pixel_t   mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    rcfb_pkg::pixel_t   mem_rdata;
    logic               blend_start;
    logic               blend_done;
    rcfb_pkg::pixel_t   blend_pix;

    rcfb_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rcfb_blend u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .start (blend_start),
        .src   (color_reg),
        .dst   (mem_rdata),
        .done  (blend_done),
        .pix   (blend_pix)
    );

    assign sw   = (16'(scr_w_reg) > 16'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(scr_w_reg);
    assign sh   = (16'(scr_h_reg) > 16'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(scr_h_reg);
    assign sw_c = coord_t'(sw);
    assign sh_c = coord_t'(sh);

    // Rectangle of the current phase, clipped to the window and the screen; a clear covers the whole screen.
    always_comb
    begin
        rx = coord_t'(x_reg);
        ry = coord_t'(y_reg);
        rw = coord_t'(w_reg);
        rh = coord_t'(h_reg);
        if (cmd_reg == CMD_OUTLINE)
        begin
            unique case (phase_reg)
                2'd0:
                begin
                    rh = 16'sd1;
                end
                2'd1:
                begin
                    ry = ry + rh - 16'sd1;
                    rh = 16'sd1;
                end
                2'd2:
                begin
                    rw = 16'sd1;
                end
                default:
                begin
                    rx = rx + rw - 16'sd1;
                    rw = 16'sd1;
                end
            endcase
        end
        cr  = coord_t'(clip_l_reg) + coord_t'(clip_w_reg);
        cb  = coord_t'(clip_t_reg) + coord_t'(clip_h_reg);
        bx0 = (rx > coord_t'(clip_l_reg)) ? rx : coord_t'(clip_l_reg);
        by0 = (ry > coord_t'(clip_t_reg)) ? ry : coord_t'(clip_t_reg);
        bx1 = rx + rw;
        by1 = ry + rh;
        if (bx0 < 16'sd0)
        begin
            bx0 = 16'sd0;
        end
        if (by0 < 16'sd0)
        begin
            by0 = 16'sd0;
        end
        if (bx1 > cr)
        begin
            bx1 = cr;
        end
        if (by1 > cb)
        begin
            by1 = cb;
        end
        if (bx1 > sw_c)
        begin
            bx1 = sw_c;
        end
        if (by1 > sh_c)
        begin
            by1 = sh_c;
        end
        if (cmd_reg == CMD_CLEAR)
        begin
            bx0 = 16'sd0;
            by0 = 16'sd0;
            bx1 = sw_c;
            by1 = sh_c;
        end
        rect_empty = (bx0 >= bx1) || (by0 >= by1);
    end

    assign rd_in_range = (x_reg >= 13'sd0) && (coord_t'(x_reg) < sw_c)
                      && (y_reg >= 13'sd0) && (coord_t'(y_reg) < sh_c);
    assign rd_prod  = y_reg[YW-1:0] * sw;
    assign rd_sum   = {1'b0, rd_prod} + RW'(x_reg[XW-1:0]);
    assign row_prod = j_reg * sw;
    assign row_step = {1'b0, row_base_reg} + AW1'(sw);
    assign pix_sum  = {1'b0, row_base_reg} + AW1'(i_reg);
    assign pix_addr = pix_sum[AW-1:0];
    assign i_inc    = i_reg + 1'b1;
    assign j_inc    = j_reg + 1'b1;
    assign last_col = (i_inc == x1_reg);
    assign last_row = (j_inc == y1_reg);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        i_next         = i_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        j_next         = j_reg;
        y1_next        = y1_reg;
        row_base_next  = row_base_reg;
        init_cnt_next  = init_cnt_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        read_data_next = read_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = pix_addr;
        mem_wdata      = color_reg;
        mem_re         = 1'b0;
        mem_raddr      = pix_addr;
        blend_start    = 1'b0;
        pix_step       = 1'b0;
        rect_finish    = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                mem_we        = 1'b1;
                mem_waddr     = init_cnt_reg;
                mem_wdata     = '0;
                init_cnt_next = init_cnt_reg + 1'b1;
                if (init_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_next   = '0;
                    phase_next = '0;
                    priority if (command == CMD_CLEAR || command == CMD_FILL
                                 || command == CMD_ALPHA)
                    begin
                        state_next = S_CLIP;
                    end
                    else if (command == CMD_OUTLINE)
                    begin
                        state_next = (rect_w > 14'sd0 && rect_h > 14'sd0) ? S_CLIP : S_DONE;
                    end
                    else if (command == CMD_READ)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_CLIP:
            begin
                if (rect_empty)
                begin
                    rect_finish = 1'b1;
                end
                else
                begin
                    x0_next    = bx0[WW-1:0];
                    i_next     = bx0[WW-1:0];
                    x1_next    = bx1[WW-1:0];
                    j_next     = by0[HW-1:0];
                    y1_next    = by1[HW-1:0];
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                row_base_next = row_prod[AW-1:0];
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                if (cmd_reg == CMD_ALPHA)
                begin
                    mem_re     = 1'b1;
                    state_next = S_BWAIT;
                end
                else
                begin
                    mem_we   = 1'b1;
                    pix_step = 1'b1;
                end
            end
            S_BWAIT:
            begin
                blend_start = 1'b1;
                state_next  = S_BMIX;
            end
            S_BMIX:
            begin
                if (blend_done)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = blend_pix;
                    pix_step  = 1'b1;
                end
            end
            S_READ:
            begin
                if (rd_in_range)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = rd_sum[AW-1:0];
                    state_next = S_RWAIT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RWAIT:
            begin
                res_next   = mem_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    read_data_next = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (pix_step)
        begin
            if (last_col)
            begin
                if (last_row)
                begin
                    rect_finish = 1'b1;
                end
                else
                begin
                    j_next        = j_inc;
                    i_next        = x0_reg;
                    row_base_next = row_step[AW-1:0];
                    state_next    = S_SCAN;
                end
            end
            else
            begin
                i_next     = i_inc;
                state_next = S_SCAN;
            end
        end

        if (rect_finish)
        begin
            if (cmd_reg == CMD_OUTLINE && phase_reg != PHASE_LAST)
            begin
                phase_next = phase_reg + 2'd1;
                state_next = S_CLIP;
            end
            else
            begin
                state_next = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            phase_reg     <= '0;
            i_reg         <= '0;
            x0_reg        <= '0;
            x1_reg        <= '0;
            j_reg         <= '0;
            y1_reg        <= '0;
            row_base_reg  <= '0;
            init_cnt_reg  <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            read_data_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            i_reg         <= i_next;
            x0_reg        <= x0_next;
            x1_reg        <= x1_next;
            j_reg         <= j_next;
            y1_reg        <= y1_next;
            row_base_reg  <= row_base_next;
            init_cnt_reg  <= init_cnt_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            read_data_reg <= read_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            cmd_reg   <= command;
            x_reg     <= pos_x;
            y_reg     <= pos_y;
            w_reg     <= rect_w;
            h_reg     <= rect_h;
            color_reg <= fill_color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg  <= 9'd256;
            scr_h_reg  <= 9'd256;
            clip_l_reg <= 13'sd0;
            clip_t_reg <= 13'sd0;
            clip_w_reg <= 14'sd256;
            clip_h_reg <= 14'sd256;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SCR_W:  scr_w_reg  <= cfg_data[8:0];
                REG_SCR_H:  scr_h_reg  <= cfg_data[8:0];
                REG_CLIP_L: clip_l_reg <= cfg_data[12:0];
                REG_CLIP_T: clip_t_reg <= cfg_data[12:0];
                REG_CLIP_W: clip_w_reg <= cfg_data;
                REG_CLIP_H: clip_h_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

endmodule
